@@ src/tfw_pkg.sv @@
// ----------------------------------------------------------------------------
// tfw_pkg: shared types and constants of the tear-free write window block
// Holds field layouts, register indexes, the control word format and the
// microcode program that sequences the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tfw_pkg;

  // Field widths
  localparam int PERIOD_W  = 20;
  localparam int TLINES_W  = 12;
  localparam int PORCH_W   = 8;
  localparam int FLOOR_W   = 16;
  localparam int TIME_IN_W = 32;
  localparam int RECT_W    = 12;
  localparam int WTIME_W   = 31;
  localparam int BEAM_W    = 13;
  localparam int EST_W     = 32;
  localparam int CMD_W     = 2;

  // Stream payload layout (lowest bit first)
  localparam int IN_NOW_LSB    = 0;
  localparam int IN_TOP_LSB    = IN_NOW_LSB + TIME_IN_W;
  localparam int IN_HEIGHT_LSB = IN_TOP_LSB + RECT_W;
  localparam int IN_WTIME_LSB  = IN_HEIGHT_LSB + RECT_W;
  localparam int IN_STAMP_LSB  = IN_WTIME_LSB + WTIME_W;
  localparam int IN_USED_W     = IN_STAMP_LSB + TIME_IN_W;
  localparam int IN_W          = ((IN_USED_W + 7) / 8) * 8;
  localparam int OUT_USED_W    = 1 + BEAM_W + EST_W;
  localparam int OUT_W         = ((OUT_USED_W + 7) / 8) * 8;

  // Configuration port
  localparam int APB_AW = 5;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_PERIOD = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_TOTAL_LINES  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SYNC_LINES   = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PORCH_LINES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_EST_FLOOR    = 3'd4;

  localparam logic [PERIOD_W-1:0] FRAME_PERIOD_RST = 20'd16667;
  localparam logic [TLINES_W-1:0] TOTAL_LINES_RST  = 12'd525;
  localparam logic [PORCH_W-1:0]  SYNC_LINES_RST   = 8'd4;
  localparam logic [PORCH_W-1:0]  PORCH_LINES_RST  = 8'd8;
  localparam logic [FLOOR_W-1:0]  EST_FLOOR_RST    = 16'd1000;
  localparam logic [EST_W-1:0]    EST_RESET        = 32'd1000;
  localparam int                  DECAY_SHIFT      = 4;

  typedef struct packed {
    logic [PERIOD_W-1:0] frame_period;
    logic [TLINES_W-1:0] total_lines;
    logic [PORCH_W-1:0]  sync_lines;
    logic [PORCH_W-1:0]  porch_lines;
    logic [FLOOR_W-1:0]  est_floor;
  } tfw_cfg_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_CHECK = 2'd0,
    CMD_WROTE = 2'd1,
    CMD_VSYNC = 2'd2,
    CMD_NONE  = 2'd3
  } tfw_cmd_e;

  // Datapath operations, one per control word
  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_MOD,
    OP_MUL_PHASE,
    OP_DIV_PROD,
    OP_BEAM,
    OP_MUL_EST,
    OP_ADV,
    OP_CLEAR,
    OP_EST_DIFF,
    OP_EST_UPD,
    OP_VSYNC,
    OP_EMIT
  } tfw_op_e;

  typedef enum logic [2:0] {
    J_NEXT,
    J_GOTO,
    J_DISPATCH,
    J_WAIT_DIV,
    J_WAIT_OUT
  } tfw_jmp_e;

  localparam int STEP_W = 4;

  typedef struct packed {
    tfw_op_e           op;
    tfw_jmp_e          jmp;
    logic [STEP_W-1:0] target;
  } tfw_ctrl_t;

  typedef struct packed {
    logic     accept;
    tfw_cmd_e cmd;
    logic     div_busy;
    logic     out_free;
  } tfw_stat_t;

  // Program addresses
  localparam logic [STEP_W-1:0] ST_IDLE       = 4'd0;
  localparam logic [STEP_W-1:0] ST_CHECK      = 4'd1;
  localparam logic [STEP_W-1:0] ST_MOD_WAIT   = 4'd2;
  localparam logic [STEP_W-1:0] ST_MUL_PHASE  = 4'd3;
  localparam logic [STEP_W-1:0] ST_DIV_PHASE  = 4'd4;
  localparam logic [STEP_W-1:0] ST_PH_WAIT    = 4'd5;
  localparam logic [STEP_W-1:0] ST_BEAM       = 4'd6;
  localparam logic [STEP_W-1:0] ST_MUL_EST    = 4'd7;
  localparam logic [STEP_W-1:0] ST_DIV_EST    = 4'd8;
  localparam logic [STEP_W-1:0] ST_EST_WAIT   = 4'd9;
  localparam logic [STEP_W-1:0] ST_ADV        = 4'd10;
  localparam logic [STEP_W-1:0] ST_CLEAR      = 4'd11;
  localparam logic [STEP_W-1:0] ST_WRITE      = 4'd12;
  localparam logic [STEP_W-1:0] ST_WRITE_UPD  = 4'd13;
  localparam logic [STEP_W-1:0] ST_EMIT       = 4'd14;
  localparam logic [STEP_W-1:0] ST_VSYNC      = 4'd15;

  function automatic tfw_ctrl_t tfw_rom(input logic [STEP_W-1:0] step);
    tfw_ctrl_t w;
    w = '{op: OP_NONE, jmp: J_NEXT, target: ST_IDLE};
    case (step)
      ST_IDLE:      w = '{op: OP_ACCEPT,    jmp: J_DISPATCH, target: ST_IDLE};
      ST_CHECK:     w = '{op: OP_DIV_MOD,   jmp: J_NEXT,     target: ST_IDLE};
      ST_MOD_WAIT:  w = '{op: OP_NONE,      jmp: J_WAIT_DIV, target: ST_IDLE};
      ST_MUL_PHASE: w = '{op: OP_MUL_PHASE, jmp: J_NEXT,     target: ST_IDLE};
      ST_DIV_PHASE: w = '{op: OP_DIV_PROD,  jmp: J_NEXT,     target: ST_IDLE};
      ST_PH_WAIT:   w = '{op: OP_NONE,      jmp: J_WAIT_DIV, target: ST_IDLE};
      ST_BEAM:      w = '{op: OP_BEAM,      jmp: J_NEXT,     target: ST_IDLE};
      ST_MUL_EST:   w = '{op: OP_MUL_EST,   jmp: J_NEXT,     target: ST_IDLE};
      ST_DIV_EST:   w = '{op: OP_DIV_PROD,  jmp: J_NEXT,     target: ST_IDLE};
      ST_EST_WAIT:  w = '{op: OP_NONE,      jmp: J_WAIT_DIV, target: ST_IDLE};
      ST_ADV:       w = '{op: OP_ADV,       jmp: J_NEXT,     target: ST_IDLE};
      ST_CLEAR:     w = '{op: OP_CLEAR,     jmp: J_GOTO,     target: ST_EMIT};
      ST_WRITE:     w = '{op: OP_EST_DIFF,  jmp: J_NEXT,     target: ST_IDLE};
      ST_WRITE_UPD: w = '{op: OP_EST_UPD,   jmp: J_GOTO,     target: ST_EMIT};
      ST_EMIT:      w = '{op: OP_EMIT,      jmp: J_WAIT_OUT, target: ST_IDLE};
      ST_VSYNC:     w = '{op: OP_VSYNC,     jmp: J_GOTO,     target: ST_EMIT};
      default:      w = '{op: OP_NONE,      jmp: J_GOTO,     target: ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

@@ src/tear_free_write_window_top.sv @@
// ----------------------------------------------------------------------------
// tear_free_write_window_top: tear-free write window predictor
// Check requests compute the beam line and the write advance from the vsync
// reference and report whether the rectangle lies clear; write-done requests
// update the write estimate; vsync requests store a nonzero reference stamp.
// ----------------------------------------------------------------------------
// The divider is DW = max(TIME_WIDTH, 32 + LINE_WIDTH) bits wide.
// Throughput: one request at a time; the next is taken the cycle after the
//   result is loaded. A check is bound by the serial divider, one quotient
//   bit per cycle, used three times (phase modulo, beam, advance).
// Reset: asynchronous, active low; registers return to their defaults, the
//   vsync reference to zero and the estimate to 1000 us. No clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module tear_free_write_window_top #(
  parameter int TIME_WIDTH = 32,
  parameter int LINE_WIDTH = 12
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Request stream
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  // now_us[31:0], rect_top[43:32], rect_height[55:44],
  // write_time_us[86:56], vsync_stamp_us[118:87], zero pad[119]
  input  wire  [tfw_pkg::IN_W-1:0]     s_axis_tdata,
  // command[1:0]
  input  wire  [tfw_pkg::CMD_W-1:0]    s_axis_tuser,
  // Result stream
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  // window_clear[0], beam_line[13:1], write_estimate[45:14], zero pad[47:46]
  output logic [tfw_pkg::OUT_W-1:0]    m_axis_tdata,
  // Register port
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [tfw_pkg::APB_AW-1:0]   paddr,
  input  wire  [tfw_pkg::APB_DW-1:0]   pwdata,
  output logic [tfw_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import tfw_pkg::*;

  localparam int DW = (TIME_WIDTH > EST_W + LINE_WIDTH) ? TIME_WIDTH : EST_W + LINE_WIDTH;

  tfw_cfg_t  cfg_q;
  tfw_ctrl_t ctrl;
  tfw_stat_t stat;

  logic                 accept;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 div_start, div_busy, out_free;
  logic [DW-1:0]        div_dividend, div_quot;
  logic [PERIOD_W-1:0]  div_divisor, div_rem;

  // --------------------------------------------------------------------------
  // Register file: write on the access phase, read back combinationally
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign reg_idx = paddr[APB_AW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.frame_period <= FRAME_PERIOD_RST;
      cfg_q.total_lines  <= TOTAL_LINES_RST;
      cfg_q.sync_lines   <= SYNC_LINES_RST;
      cfg_q.porch_lines  <= PORCH_LINES_RST;
      cfg_q.est_floor    <= EST_FLOOR_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_FRAME_PERIOD: cfg_q.frame_period <= pwdata[PERIOD_W-1:0];
        REG_TOTAL_LINES:  cfg_q.total_lines  <= pwdata[TLINES_W-1:0];
        REG_SYNC_LINES:   cfg_q.sync_lines   <= pwdata[PORCH_W-1:0];
        REG_PORCH_LINES:  cfg_q.porch_lines  <= pwdata[PORCH_W-1:0];
        REG_EST_FLOOR:    cfg_q.est_floor    <= pwdata[FLOOR_W-1:0];
        default: ;  // drop writes beyond the register list
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FRAME_PERIOD: prdata = APB_DW'(cfg_q.frame_period);
      REG_TOTAL_LINES:  prdata = APB_DW'(cfg_q.total_lines);
      REG_SYNC_LINES:   prdata = APB_DW'(cfg_q.sync_lines);
      REG_PORCH_LINES:  prdata = APB_DW'(cfg_q.porch_lines);
      REG_EST_FLOOR:    prdata = APB_DW'(cfg_q.est_floor);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Request handshake: only the dispatch step of the program takes a request
  // --------------------------------------------------------------------------
  assign s_axis_tready = (ctrl.op == OP_ACCEPT);
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    stat.accept   = accept;
    stat.cmd      = tfw_cmd_e'(s_axis_tuser);
    stat.div_busy = div_busy;
    stat.out_free = out_free;
  end

  tfw_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctrl_o (ctrl)
  );

  // Shared divider: phase modulo, beam scaling and advance scaling
  tfw_div #(
    .DIV_W (DW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .busy_o      (div_busy),
    .quotient_o  (div_quot),
    .remainder_o (div_rem)
  );

  tfw_dp #(
    .TIME_WIDTH (TIME_WIDTH),
    .LINE_WIDTH (LINE_WIDTH),
    .DIV_W      (DW)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .ctrl_i         (ctrl),
    .cfg_i          (cfg_q),
    .accept_i       (accept),
    .now_i          (s_axis_tdata[IN_NOW_LSB +: TIME_IN_W]),
    .top_i          (s_axis_tdata[IN_TOP_LSB +: RECT_W]),
    .height_i       (s_axis_tdata[IN_HEIGHT_LSB +: RECT_W]),
    .wtime_i        (s_axis_tdata[IN_WTIME_LSB +: WTIME_W]),
    .stamp_i        (s_axis_tdata[IN_STAMP_LSB +: TIME_IN_W]),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_quot_i     (div_quot),
    .div_rem_i      (div_rem),
    .out_free_o     (out_free),
    .out_ready_i    (m_axis_tready),
    .out_valid_o    (m_axis_tvalid),
    .out_data_o     (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // No request is taken while the divider still works on the previous one
  a_no_accept_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> !s_axis_tready)
    else $error("request port open while divider busy");

  // One request at a time: the port closes right after a request is taken
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second request taken back to back");

  // A result only appears from the emit step
  a_result_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(ctrl.op == OP_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

`default_nettype wire

@@ src/tfw_div.sv @@
// ----------------------------------------------------------------------------
// tfw_div: serial restoring divider
// One quotient bit per cycle; leaves quotient and remainder in place.
// ----------------------------------------------------------------------------
`default_nettype none

module tfw_div #(
  parameter int DIV_W = 44
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  wire                           start_i,
  input  wire  [DIV_W-1:0]              dividend_i,
  input  wire  [tfw_pkg::PERIOD_W-1:0]  divisor_i,
  output logic                          busy_o,
  output logic [DIV_W-1:0]              quotient_o,
  output logic [tfw_pkg::PERIOD_W-1:0]  remainder_o
);
  import tfw_pkg::*;

  localparam int CNT_W = $clog2(DIV_W + 1);

  logic             busy_q, busy_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DIV_W-1:0] quo_q;
  logic [PERIOD_W-1:0] rem_q;
  logic [PERIOD_W:0]   trial;
  logic [PERIOD_W:0]   trial_sub;
  logic                ge;

  always_comb begin
    trial     = {rem_q, quo_q[DIV_W-1]};
    trial_sub = trial - {1'b0, divisor_i};
    ge        = (trial >= {1'b0, divisor_i});
  end

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_W);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  // Shift one dividend bit into the partial remainder per cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIV_W-2:0], ge};
      rem_q <= ge ? trial_sub[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
    end
  end

  assign busy_o      = busy_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

@@ src/tfw_seq.sv @@
// ----------------------------------------------------------------------------
// tfw_seq: microcode sequencer
// Step counter over the program ROM, with command dispatch and wait jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module tfw_seq (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  tfw_pkg::tfw_stat_t   stat_i,
  output tfw_pkg::tfw_ctrl_t   ctrl_o
);
  import tfw_pkg::*;

  logic [STEP_W-1:0] step_q, step_d;
  tfw_ctrl_t         ctrl;

  always_comb begin
    ctrl = tfw_rom(step_q);
  end

  always_comb begin
    step_d = step_q;
    case (ctrl.jmp)
      J_NEXT:     step_d = step_q + 1'b1;
      J_GOTO:     step_d = ctrl.target;
      J_DISPATCH: begin
        if (stat_i.accept) begin
          case (stat_i.cmd)
            CMD_CHECK: step_d = ST_CHECK;
            CMD_WROTE: step_d = ST_WRITE;
            CMD_VSYNC: step_d = ST_VSYNC;
            default:   step_d = ST_EMIT;
          endcase
        end
      end
      J_WAIT_DIV: begin
        if (!stat_i.div_busy) begin
          step_d = step_q + 1'b1;
        end
      end
      J_WAIT_OUT: begin
        if (stat_i.out_free) begin
          step_d = ctrl.target;
        end
      end
      default:    step_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

  assign ctrl_o = ctrl;

endmodule

`default_nettype wire

@@ src/tfw_dp.sv @@
// ----------------------------------------------------------------------------
// tfw_dp: datapath of the tear-free write window
// Holds the request, the working registers, the vsync reference, the
// estimate and the result register, which the microcode operations update.
// ----------------------------------------------------------------------------
`default_nettype none

module tfw_dp #(
  parameter int TIME_WIDTH = 32,
  parameter int LINE_WIDTH = 12,
  parameter int DIV_W      = 44
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  tfw_pkg::tfw_ctrl_t            ctrl_i,
  input  tfw_pkg::tfw_cfg_t             cfg_i,
  input  wire                           accept_i,
  input  wire  [tfw_pkg::TIME_IN_W-1:0] now_i,
  input  wire  [tfw_pkg::RECT_W-1:0]    top_i,
  input  wire  [tfw_pkg::RECT_W-1:0]    height_i,
  input  wire  [tfw_pkg::WTIME_W-1:0]   wtime_i,
  input  wire  [tfw_pkg::TIME_IN_W-1:0] stamp_i,
  output logic                          div_start_o,
  output logic [DIV_W-1:0]              div_dividend_o,
  output logic [tfw_pkg::PERIOD_W-1:0]  div_divisor_o,
  input  wire  [DIV_W-1:0]              div_quot_i,
  input  wire  [tfw_pkg::PERIOD_W-1:0]  div_rem_i,
  output logic                          out_free_o,
  input  wire                           out_ready_i,
  output logic                          out_valid_o,
  output logic [tfw_pkg::OUT_W-1:0]     out_data_o
);
  import tfw_pkg::*;

  localparam int CW    = LINE_WIDTH + 4;           // signed line arithmetic
  localparam int ADV_W = LINE_WIDTH + 3;
  localparam int BW    = (CW > BEAM_W) ? CW : BEAM_W;
  localparam logic [DIV_W-1:0] ADV_LIM = DIV_W'(1) << (LINE_WIDTH + 2);

  // Request capture
  logic [TIME_WIDTH-1:0] now_q, stamp_q;
  logic [LINE_WIDTH-1:0] top_q, height_q;
  logic [WTIME_W-1:0]    wtime_q;

  // Working registers
  logic [DIV_W-1:0]  prod_q;
  logic [CW-1:0]     beam_q;
  logic [ADV_W-1:0]  adv_q;
  logic              clear_q;
  logic              gt_q;
  logic [EST_W-1:0]  diff_q;

  // State
  logic [TIME_WIDTH-1:0] ref_q;
  logic [EST_W-1:0]      est_q, est_d;
  logic                  out_valid_q, out_valid_d;
  logic [OUT_W-1:0]      out_data_q;

  // Width adjustments
  logic [TIME_WIDTH+TIME_IN_W-1:0] now_ext, stamp_ext;
  logic [LINE_WIDTH+RECT_W-1:0]    top_ext, height_ext, lines_ext;
  logic [LINE_WIDTH-1:0]           lines;
  logic [TIME_WIDTH-1:0]           elapsed;
  logic [DIV_W+TIME_WIDTH-1:0]     elapsed_ext;
  logic [PERIOD_W+LINE_WIDTH-1:0]  mul_phase;
  logic [EST_W+LINE_WIDTH-1:0]     mul_est;
  logic [DIV_W+PERIOD_W+LINE_WIDTH-1:0] mul_phase_ext;
  logic [DIV_W+EST_W+LINE_WIDTH-1:0]    mul_est_ext;
  logic [CW-1:0]                   beam_d;
  logic [ADV_W-1:0]                adv_d;
  logic signed [CW-1:0]            s_beam, s_adv, s_top, s_height, s_lines;
  logic                            clear_d;
  logic [EST_W-1:0]                sample, decayed, floor_ext;
  logic [BW-1:0]                   beam_sx;

  assign now_ext     = {{TIME_WIDTH{1'b0}}, now_i};
  assign stamp_ext   = {{TIME_WIDTH{1'b0}}, stamp_i};
  assign top_ext     = {{LINE_WIDTH{1'b0}}, top_i};
  assign height_ext  = {{LINE_WIDTH{1'b0}}, height_i};
  assign lines_ext   = {{LINE_WIDTH{1'b0}}, cfg_i.total_lines};
  assign lines       = lines_ext[LINE_WIDTH-1:0];

  assign elapsed       = now_q - ref_q;
  assign elapsed_ext   = {{DIV_W{1'b0}}, elapsed};
  assign mul_phase     = div_rem_i * lines;
  assign mul_est       = est_q * lines;
  assign mul_phase_ext = {{DIV_W{1'b0}}, mul_phase};
  assign mul_est_ext   = {{DIV_W{1'b0}}, mul_est};

  // Divider request; a zero period divides as one
  assign div_start_o    = (ctrl_i.op == OP_DIV_MOD) || (ctrl_i.op == OP_DIV_PROD);
  assign div_dividend_o = (ctrl_i.op == OP_DIV_MOD) ? elapsed_ext[DIV_W-1:0] : prod_q;
  assign div_divisor_o  = (cfg_i.frame_period == '0) ? PERIOD_W'(1) : cfg_i.frame_period;

  // Beam line and clamped advance
  assign beam_d = CW'(div_quot_i[LINE_WIDTH-1:0]) - CW'(cfg_i.sync_lines)
                - CW'(cfg_i.porch_lines);
  assign adv_d  = (div_quot_i >= ADV_LIM) ? ADV_LIM[ADV_W-1:0] : div_quot_i[ADV_W-1:0];

  always_comb begin
    s_beam   = signed'(beam_q);
    s_adv    = signed'(CW'(adv_q));
    s_top    = signed'(CW'(top_q));
    s_height = signed'(CW'(height_q));
    s_lines  = signed'(CW'(lines));
    clear_d  = ((s_beam + s_adv) < s_top) ||
               ((s_beam > (s_top + s_height)) && ((s_lines - s_beam + s_top) > s_adv));
  end

  // Estimate: rise at once, decay by a sixteenth of the gap, hold the floor
  assign sample    = {wtime_q, 1'b0};
  assign decayed   = est_q - (diff_q >> DECAY_SHIFT);
  assign floor_ext = EST_W'(cfg_i.est_floor);

  always_comb begin
    est_d = est_q;
    if (ctrl_i.op == OP_EST_UPD) begin
      if (gt_q) begin
        est_d = sample;
      end else if (decayed < floor_ext) begin
        est_d = floor_ext;
      end else begin
        est_d = decayed;
      end
    end
  end

  assign beam_sx    = BW'(signed'(beam_q));
  assign out_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if ((ctrl_i.op == OP_EMIT) && out_free_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q       <= '0;
      est_q       <= EST_RESET;
      out_valid_q <= 1'b0;
    end else begin
      est_q       <= est_d;
      out_valid_q <= out_valid_d;
      if ((ctrl_i.op == OP_VSYNC) && (stamp_q != '0)) begin
        ref_q <= stamp_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      now_q    <= now_ext[TIME_WIDTH-1:0];
      stamp_q  <= stamp_ext[TIME_WIDTH-1:0];
      top_q    <= top_ext[LINE_WIDTH-1:0];
      height_q <= height_ext[LINE_WIDTH-1:0];
      wtime_q  <= wtime_i;
      clear_q  <= 1'b0;
      beam_q   <= '0;
    end
    case (ctrl_i.op)
      OP_MUL_PHASE: prod_q  <= mul_phase_ext[DIV_W-1:0];
      OP_MUL_EST:   prod_q  <= mul_est_ext[DIV_W-1:0];
      OP_BEAM:      beam_q  <= beam_d;
      OP_ADV:       adv_q   <= adv_d;
      OP_CLEAR:     clear_q <= clear_d;
      OP_EST_DIFF: begin
        gt_q   <= (sample > est_q);
        diff_q <= est_q - sample;
      end
      default: ;
    endcase
    if ((ctrl_i.op == OP_EMIT) && out_free_o) begin
      out_data_q <= OUT_W'({est_q, beam_sx[BEAM_W-1:0], clear_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  // The estimate starts at a nonzero value and no update can bring it to zero
  a_est_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    est_q != '0)
    else $error("write estimate reached zero");
`endif

endmodule

`default_nettype wire

@@ tb/tear_free_write_window_top_test.sv @@
// ----------------------------------------------------------------------------
// tear_free_write_window_top_test: self-checking bench for the window predictor
// Drives check, write-done, vsync and unused requests on the request stream and
// programs the timing registers between phases. A behavioral predictor holds
// its own copy of the timing setup, the vsync reference and the write estimate,
// and each result on the result stream is compared with the oldest expectation.
// ----------------------------------------------------------------------------
`default_nettype none

module tear_free_write_window_top_test;
  import tfw_pkg::*;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 11;
  localparam int DRAIN_CYCLES   = 300;
  localparam int TIMEOUT        = 20_000_000;
  localparam int REPORT_LIMIT   = 10;
  localparam int SWAP_IDLE_AT   = 430;     // accepted requests before the idle swap
  localparam int QUIET_AT       = 860;     // accepted requests before idling stops
  localparam int HOLDOFF_AT     = 700;
  localparam int HOLDOFF_CYCLES = 900;

  // Request as it travels: everything below cmd maps onto tdata, now_us lowest
  typedef struct packed {
    tfw_cmd_e              cmd;
    logic [TIME_IN_W-1:0]  stamp;
    logic [WTIME_W-1:0]    wtime;
    logic [RECT_W-1:0]     height;
    logic [RECT_W-1:0]     top;
    logic [TIME_IN_W-1:0]  now;
  } window_req_t;

  // Result in tdata order: window_clear lowest
  typedef struct packed {
    logic [EST_W-1:0]  est;
    logic [BEAM_W-1:0] beam;
    logic              clear;
  } window_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              s_axis_tvalid = 1'b0;
  wire               s_axis_tready;
  // now_us, rect_top, rect_height, write_time_us, vsync_stamp_us, zero pad
  logic [IN_W-1:0]   s_axis_tdata = '0;
  // command
  logic [CMD_W-1:0]  s_axis_tuser = CMD_NONE;
  wire               m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // window_clear, beam_line, write_estimate, zero pad
  wire  [OUT_W-1:0]  m_axis_tdata;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  wire  [APB_DW-1:0] prdata;
  wire               pready;

  tear_free_write_window_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  // Predictor state: timing setup as programmed, vsync reference, estimate
  tfw_cfg_t          timing_cfg = '{frame_period: FRAME_PERIOD_RST,
                                    total_lines:  TOTAL_LINES_RST,
                                    sync_lines:   SYNC_LINES_RST,
                                    porch_lines:  PORCH_LINES_RST,
                                    est_floor:    EST_FLOOR_RST};
  logic [TIME_IN_W-1:0] vsync_ref_us = '0;
  logic [EST_W-1:0]     write_est_us = EST_RESET;

  window_req_t    pending_requests[$];
  window_result_t expected_windows[$];
  window_req_t    offered;
  int             accepted_count = 0;
  int             mismatch_count = 0;
  int             holdoff_left = 0;
  bit             holdoff_done = 1'b0;

  // Apply one request to the predictor state and return the result it yields
  function automatic window_result_t step_window(input window_req_t r);
    window_result_t       res;
    logic [TIME_IN_W-1:0] elapsed;
    logic [EST_W-1:0]     sample;
    logic [EST_W-1:0]     decayed;
    longint               period, lines, phase, beam, advance, top, height;
    longint               sync, porch, est;
    res = '0;
    case (r.cmd)
      CMD_CHECK: begin
        period = timing_cfg.frame_period;
        if (period == 0) period = 1;
        lines   = timing_cfg.total_lines;
        sync    = timing_cfg.sync_lines;
        porch   = timing_cfg.porch_lines;
        est     = write_est_us;
        top     = r.top;
        height  = r.height;
        elapsed = r.now - vsync_ref_us;       // wraps at the time width
        phase   = elapsed;
        phase   = phase % period;
        beam    = (phase * lines) / period - sync - porch;
        advance = (est * lines) / period;
        res.clear = (beam + advance < top) ||
                    (beam > top + height && lines - beam + top > advance);
        res.beam  = beam[BEAM_W-1:0];
      end
      CMD_WROTE: begin
        // Rise at once to twice the write time, else decay by a sixteenth down to the floor
        sample = {r.wtime, 1'b0};
        if (sample > write_est_us) begin
          write_est_us = sample;
        end else begin
          decayed = write_est_us - ((write_est_us - sample) >> DECAY_SHIFT);
          write_est_us = (decayed < timing_cfg.est_floor) ? EST_W'(timing_cfg.est_floor)
                                                          : decayed;
        end
      end
      CMD_VSYNC: begin
        if (r.stamp != '0) vsync_ref_us = r.stamp;
      end
      default: ;
    endcase
    res.est = write_est_us;
    return res;
  endfunction

  // Idle pattern: sender light / receiver heavy, then swapped, then none
  function automatic bit sender_rests();
    if (accepted_count < SWAP_IDLE_AT) return $urandom_range(0, 99) < 28;
    if (accepted_count < QUIET_AT) return $urandom_range(0, 99) < 77;
    return 1'b0;
  endfunction

  function automatic bit receiver_rests();
    if (accepted_count < SWAP_IDLE_AT) return $urandom_range(0, 99) < 77;
    if (accepted_count < QUIET_AT) return $urandom_range(0, 99) < 28;
    return 1'b0;
  endfunction

  // Request driver: hold the offer until taken, predict at acceptance,
  // then offer the next pending request unless this cycle is an idle one
  always @(posedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !s_axis_tready)) begin
      if (s_axis_tvalid) begin
        expected_windows.push_back(step_window(offered));
        accepted_count <= accepted_count + 1;
      end
      if (pending_requests.size() != 0 && !sender_rests()) begin
        offered = pending_requests.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(offered[IN_USED_W-1:0]);
        s_axis_tuser  <= offered.cmd;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // One long receiver hold-off while requests keep coming, so the block
  // fills up and drops its tready
  always @(posedge clk_i) begin
    if (holdoff_left != 0) begin
      holdoff_left <= holdoff_left - 1;
    end else if (!holdoff_done && accepted_count == HOLDOFF_AT) begin
      holdoff_left <= HOLDOFF_CYCLES;
      holdoff_done <= 1'b1;
    end
  end

  // Result monitor: compare each taken result with the oldest expectation
  always @(posedge clk_i) begin
    window_result_t seen;
    window_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen = m_axis_tdata[OUT_USED_W-1:0];
      if (expected_windows.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("unexpected result: clear %0d beam %0d estimate %0d",
                   seen.clear, $signed(seen.beam), seen.est);
      end else begin
        want = expected_windows.pop_front();
        if (seen != want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT)
            $display("result mismatch (expected/actual): clear %0d/%0d beam %0d/%0d estimate %0d/%0d",
                     want.clear, seen.clear, $signed(want.beam), $signed(seen.beam),
                     want.est, seen.est);
        end
      end
    end
    m_axis_tready <= (holdoff_left == 0) && !receiver_rests();
  end

  // Fill every field at random; callers set the ones their command uses
  function automatic window_req_t random_request(input tfw_cmd_e c);
    window_req_t r;
    r = '{cmd: c, stamp: $urandom, wtime: WTIME_W'($urandom), height: RECT_W'($urandom),
          top: RECT_W'($urandom), now: $urandom};
    return r;
  endfunction

  task automatic push_check(input logic [TIME_IN_W-1:0] now, input logic [RECT_W-1:0] top,
                            input logic [RECT_W-1:0] height);
    window_req_t r;
    r = random_request(CMD_CHECK);
    r.now = now;
    r.top = top;
    r.height = height;
    pending_requests.push_back(r);
  endtask

  task automatic push_wrote(input logic [WTIME_W-1:0] wtime);
    window_req_t r;
    r = random_request(CMD_WROTE);
    r.wtime = wtime;
    pending_requests.push_back(r);
  endtask

  task automatic push_vsync(input logic [TIME_IN_W-1:0] stamp);
    window_req_t r;
    r = random_request(CMD_VSYNC);
    r.stamp = stamp;
    pending_requests.push_back(r);
  endtask

  // Register write: setup cycle, access cycle, written at the access edge
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_FRAME_PERIOD: timing_cfg.frame_period = data[PERIOD_W-1:0];
      REG_TOTAL_LINES:  timing_cfg.total_lines  = data[TLINES_W-1:0];
      REG_SYNC_LINES:   timing_cfg.sync_lines   = data[PORCH_W-1:0];
      REG_PORCH_LINES:  timing_cfg.porch_lines  = data[PORCH_W-1:0];
      REG_EST_FLOOR:    timing_cfg.est_floor    = data[FLOOR_W-1:0];
      default: ;
    endcase
  endtask

  // Program all timing registers; junk above each field must be dropped
  task automatic set_timing(input logic [PERIOD_W-1:0] period,
                            input logic [TLINES_W-1:0] lines,
                            input logic [PORCH_W-1:0] sync, input logic [PORCH_W-1:0] porch,
                            input logic [FLOOR_W-1:0] est_floor);
    reg_write(REG_FRAME_PERIOD, {(APB_DW-PERIOD_W)'($urandom), period});
    reg_write(REG_TOTAL_LINES,  {(APB_DW-TLINES_W)'($urandom), lines});
    reg_write(REG_SYNC_LINES,   {(APB_DW-PORCH_W)'($urandom), sync});
    reg_write(REG_PORCH_LINES,  {(APB_DW-PORCH_W)'($urandom), porch});
    reg_write(REG_EST_FLOOR,    {(APB_DW-FLOOR_W)'($urandom), est_floor});
  endtask

  // Hold the sender until every expected result has come back
  task automatic wait_idle();
    do @(posedge clk_i);
    while (pending_requests.size() != 0 || s_axis_tvalid || expected_windows.size() != 0);
  endtask

  // Mostly frames: a vsync stamp, then checks a few frames on and some
  // write-done requests; the rest is noise over all commands and fields
  task automatic fill_random_phase(input int count);
    int                   n;
    int                   pick;
    int unsigned          span;
    int unsigned          lines;
    logic [TIME_IN_W-1:0] stamp;
    window_req_t          r;
    n = 0;
    while (n < count) begin
      pick  = $urandom_range(0, 99);
      span  = (timing_cfg.frame_period == '0) ? 3 : 3 * timing_cfg.frame_period;
      lines = timing_cfg.total_lines;
      if (pick < 85) begin
        stamp = (pick < 10) ? 32'hFFFF_FFFF - $urandom_range(0, span) : $urandom;
        if (stamp == '0) stamp = 32'd1;
        push_vsync(stamp);
        n++;
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) != 0)
            push_check(stamp + $urandom_range(0, span), RECT_W'($urandom_range(0, lines)),
                       RECT_W'($urandom_range(0, lines / 3)));
          else
            push_wrote(WTIME_W'($urandom_range(0, 12000)));
          n++;
        end
      end else begin
        r = random_request(tfw_cmd_e'($urandom_range(0, 3)));
        if (r.cmd == CMD_WROTE) r.wtime = WTIME_W'($urandom_range(0, 40000));
        pending_requests.push_back(r);
        n++;
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part at the reset timing setup
    push_check(32'h0000_0000, 12'd0, 12'd0);          // no vsync yet, time zero
    push_check(32'hFFFF_FFFF, 12'hFFF, 12'hFFF);      // no vsync yet, top of time
    push_check(32'd5000, 12'd300, 12'd10);
    push_vsync(32'h0000_0000);                        // zero stamp is ignored
    push_check(32'd50101, 12'd0, 12'd0);
    push_vsync(32'hFFFF_F000);
    push_check(32'h0000_0800, 12'd200, 12'd50);       // elapsed time wraps
    push_check(32'hFFFF_F000, 12'd0, 12'hFFF);        // in blanking, negative line
    pending_requests.push_back(random_request(CMD_NONE));
    push_wrote(31'd500);                              // sample equals estimate
    push_wrote(31'd501);                              // rise at once
    push_wrote(31'd0);                                // decay down to the floor
    push_wrote(31'd20000);
    push_check(32'hFFFF_F000 + 32'd8000, 12'd10, 12'd5);
    push_wrote(31'd0);
    push_wrote(31'd0);
    push_wrote(31'd0);
    push_vsync(32'h1234_5678);
    push_check(32'h1234_5678 + 32'd16666, 12'hFFF, 12'd0);
    push_check(32'h1234_5678 + 32'd400, 12'd0, 12'd0);
    push_check(32'h1234_5678 + 32'd9000, 12'd100, 12'd20);
    pending_requests.push_back(random_request(CMD_NONE));
    wait_idle();

    // Writes past the register list must leave the setup alone
    for (int i = int'(REG_EST_FLOOR) + 1; i < (1 << REG_IDX_W); i++)
      reg_write(REG_IDX_W'(i), $urandom);

    set_timing(20'd8333, 12'd1125, 8'd5, 8'd36, 16'd500);
    fill_random_phase(250);
    wait_idle();

    set_timing(20'hFFFFF, 12'hFFF, 8'hFF, 8'hFF, 16'hFFFF);
    fill_random_phase(250);
    wait_idle();

    set_timing(20'd1, 12'd1, 8'd0, 8'd0, 16'd0);
    fill_random_phase(150);
    wait_idle();

    // A zero period acts as one
    set_timing(20'd0, 12'hFFF, 8'd0, 8'd0, 16'd0);
    fill_random_phase(100);
    wait_idle();

    set_timing(20'd97, 12'd300, 8'd2, 8'd3, 16'd10);
    fill_random_phase(250);
    wait_idle();

    set_timing(20'd1000000, 12'd2000, 8'd10, 8'd20, 16'd2000);
    fill_random_phase(250);
    wait_idle();

    // Largest write time last: the advance then needs more than 32 bits
    set_timing(FRAME_PERIOD_RST, 12'hFFF, SYNC_LINES_RST, PORCH_LINES_RST, EST_FLOOR_RST);
    push_vsync(32'd1000);
    push_wrote(31'h7FFF_FFFF);
    push_check(32'd1000, 12'hFFF, 12'd0);
    push_check(32'd9000, 12'd0, 12'd0);
    push_check(32'd17000, 12'd2000, 12'd100);
    push_wrote(31'd0);
    push_check(32'd12000, 12'd50, 12'd50);
    wait_idle();

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_windows.size() == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

`default_nettype wire
